@@ sv/pcmfc_pkg.sv @@
//------------------------------------------------------------------------------
// pcmfc_pkg
// Shared types and constants for the PCM format convert / downmix core.
//------------------------------------------------------------------------------
package pcmfc_pkg;

  // Sample format codes
  localparam logic [3:0] FMT_S16     = 4'd0;
  localparam logic [3:0] FMT_U8P     = 4'd1;
  localparam logic [3:0] FMT_S16P    = 4'd2;
  localparam logic [3:0] FMT_S32P    = 4'd3;
  localparam logic [3:0] FMT_FLTP    = 4'd4;
  localparam logic [3:0] FMT_DBLP    = 4'd5;
  localparam logic [3:0] FMT_U8      = 4'd6;
  localparam logic [3:0] FMT_S32     = 4'd7;
  localparam logic [3:0] FMT_FLT     = 4'd8;
  localparam logic [3:0] FMT_DBL     = 4'd9;

  // Register indexes
  localparam logic [1:0] REG_FORMAT  = 2'd0;
  localparam logic [1:0] REG_IVOL    = 2'd1;
  localparam logic [1:0] REG_FVOL    = 2'd2;
  localparam logic [1:0] REG_CHANS   = 2'd3;

  localparam logic [6:0]  VOL_MAX    = 7'd100;
  localparam logic [47:0] FIX_CAP    = 48'h8000_0000_0000;
  localparam logic [15:0] PCM_MAX    = 16'h7FFF;

  // Path select decided at decode
  typedef enum logic [1:0] {
    PATH_PASS,
    PATH_INT,
    PATH_FIX,
    PATH_BAD
  } path_t;

  // Control bits traveling with a beat
  typedef struct packed {
    path_t path;
    logic  mix;        // 3-way downmix active
    logic  right_valid;
    logic  eob;
  } ctl_t;

  // Config snapshot
  typedef struct packed {
    logic [3:0] fmt;
    logic [6:0] ivol;
    logic [6:0] fvol;
    logic [3:0] chans;
  } cfg_t;

endpackage

@@ sv/pcmfc_fix_unpack.sv @@
//------------------------------------------------------------------------------
// pcmfc_fix_unpack
// Converts a float or double word to signed fixed point, 32 fraction bits,
// magnitude saturated at 2^47. Output is sign plus 48-bit magnitude.
//------------------------------------------------------------------------------
module pcmfc_fix_unpack (
  input  logic [63:0] word,
  input  logic        is_dbl,
  output logic        neg,
  output logic [47:0] mag
);
  import pcmfc_pkg::*;

  logic [52:0] mant;
  logic [11:0] exp_s;     // biased exponent
  logic        is_max;
  logic        frac_nz;
  logic signed [12:0] sh; // left shift amount
  logic [52:0] rsh;
  logic [100:0] lsh;

  always_comb begin
    mant    = '0;
    exp_s   = '0;
    is_max  = 1'b0;
    frac_nz = 1'b0;
    if (is_dbl) begin
      neg     = word[63];
      exp_s   = {1'b0, word[62:52]};
      frac_nz = |word[51:0];
      is_max  = &word[62:52];
      mant    = {(|word[62:52]), word[51:0]};
      sh      = (|word[62:52]) ? $signed({1'b0, exp_s}) - 13'sd1043 : -13'sd1042;
    end else begin
      neg     = word[31];
      exp_s   = {4'd0, word[30:23]};
      frac_nz = |word[22:0];
      is_max  = &word[30:23];
      mant    = {29'd0, (|word[30:23]), word[22:0]};
      sh      = (|word[30:23]) ? $signed({1'b0, exp_s}) - 13'sd118 : -13'sd117;
    end
    rsh = '0;
    lsh = '0;
    mag = '0;
    if (is_max) begin
      mag = frac_nz ? 48'd0 : FIX_CAP;
    end else if (mant == '0) begin
      mag = '0;
    end else if (sh >= 0) begin
      // saturate when shifted value passes the cap
      if (sh > 13'sd47) begin
        mag = FIX_CAP;
      end else begin
        lsh = {48'd0, mant} << sh[5:0];
        mag = (|lsh[100:48] || lsh[47:0] > FIX_CAP) ? FIX_CAP : lsh[47:0];
      end
    end else begin
      if (sh <= -13'sd64) begin
        mag = '0;
      end else begin
        rsh = mant >> (7'd0 - {sh[6], sh[5:0]});
        mag = (|rsh[52:48] || rsh[47:0] > FIX_CAP) ? FIX_CAP : rsh[47:0];
      end
    end
  end
endmodule

@@ sv/pcmfc_scale.sv @@
//------------------------------------------------------------------------------
// pcmfc_scale
// Fixed magnitude times float scale, >>32, clamp. Multiply cut in two
// partial products, registered when enable is high.
//------------------------------------------------------------------------------
module pcmfc_scale (
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] mag,
  input  logic [14:0] scale,
  output logic [15:0] res
);
  import pcmfc_pkg::*;

  logic [38:0] plo_r;   // mag[23:0]*scale
  logic [38:0] phi_r;   // mag[47:24]*scale
  logic [63:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= mag[23:0]  * scale;
      phi_r <= mag[47:24] * scale;
    end
  end

  always_comb begin
    sum = {1'b0, phi_r, 24'd0} + {25'd0, plo_r};
    res = (|sum[63:47]) ? PCM_MAX : {1'b0, sum[46:32]};
    if (sum[63:32] > 32'h7FFF) res = PCM_MAX;
  end
endmodule

@@ sv/pcm_format_convert_downmix_core.sv @@
//------------------------------------------------------------------------------
// pcm_format_convert_downmix_core
// Converts raw PCM words (u8/s16/s32/float/double, planar or interleaved) to
// signed 16-bit stereo with 5/6-channel float downmix.
//
// Channels: in_* (valid/ready), one frame per beat; out_* (valid/ready), one
// result per beat; cfg_* (valid/ready) writes register cfg_index.
// Pipeline: 5 register stages, throughput one beat per cycle while out is
// not stalled. Stages: decode/unpack, mix sum and upper third, lower third,
// scale multiply and int /100, output.
// The whole pipe advances together: when out is stalled and the last stage
// holds a beat, every stage holds; in_ready is low only then.
// Reset clears all stage valids and loads register defaults: format s16,
// volumes 100, two source channels. cfg_ready is always high; writes are
// expected only while the pipe is empty.
//------------------------------------------------------------------------------
module pcm_format_convert_downmix_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         in_chan0_word,
  input  logic [63:0]         in_chan1_word,
  input  logic [63:0]         in_chan2_word,
  input  logic [63:0]         in_chan3_word,
  input  logic [63:0]         in_chan4_word,
  input  logic [63:0]         in_chan5_word,
  input  logic                in_end_of_block,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_left_sample,
  output logic signed [15:0]  out_right_sample,
  output logic                out_right_valid,
  output logic                out_unsupported,
  output logic                out_end_of_block_out,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data
);
  import pcmfc_pkg::*;

  cfg_t cfg_r;
  logic adv;

  // config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{fmt: FMT_S16, ivol: VOL_MAX, fvol: VOL_MAX, chans: 4'd2};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORMAT: cfg_r.fmt   <= cfg_data[3:0];
        REG_IVOL:   cfg_r.ivol  <= cfg_data;
        REG_FVOL:   cfg_r.fvol  <= cfg_data;
        REG_CHANS:  cfg_r.chans <= cfg_data[3:0];
        default:    cfg_r.fmt   <= cfg_r.fmt;
      endcase
    end
  end

  logic [6:0]  ivol, fvol;
  logic [14:0] fscale;
  logic [21:0] fscale_num;
  logic [44:0] fscale_prod;
  assign ivol = (cfg_r.ivol > VOL_MAX) ? VOL_MAX : cfg_r.ivol;
  assign fvol = (cfg_r.fvol > VOL_MAX) ? VOL_MAX : cfg_r.fvol;
  // 0x7FFF*vol/100: config-static; the user must change it only while idle (block does not enforce this)
  // 0x7FFF*vol as shift minus vol, /100 as multiply by ceil(2^29/100)
  assign fscale_num  = {fvol, 15'd0} - {15'd0, fvol};
  assign fscale_prod = fscale_num * 23'd5368710;
  assign fscale      = fscale_prod[43:29];

  // global advance
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  assign adv      = !v5_r || out_ready;
  assign in_ready = adv;

  //---------------- stage 1: decode, unpack ----------------
  logic stereo, dbl;
  ctl_t ctl_nxt, ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  logic [63:0] w0, w1, wsl, wsr;
  logic n0, n1, n2, nsl, nsr;
  logic [47:0] m0, m1, m2, msl, msr;
  logic signed [16:0] il_nxt, ir_nxt;

  assign stereo = cfg_r.chans >= 4'd2;
  assign dbl    = (cfg_r.fmt == FMT_DBLP) || (cfg_r.fmt == FMT_DBL);
  assign w0  = (cfg_r.fmt == FMT_FLT) ? {32'd0, in_chan0_word[31:0]} : in_chan0_word;
  assign w1  = in_chan1_word;
  assign wsl = (cfg_r.chans == 4'd6) ? in_chan4_word : in_chan3_word;
  assign wsr = (cfg_r.chans == 4'd6) ? in_chan5_word : in_chan4_word;

  pcmfc_fix_unpack u_fx0 (.word(w0), .is_dbl(dbl), .neg(n0), .mag(m0));
  pcmfc_fix_unpack u_fx1 (.word(w1), .is_dbl(dbl), .neg(n1), .mag(m1));
  pcmfc_fix_unpack u_fx2 (.word(in_chan2_word), .is_dbl(1'b0), .neg(n2), .mag(m2));
  pcmfc_fix_unpack u_fxl (.word(wsl), .is_dbl(1'b0), .neg(nsl), .mag(msl));
  pcmfc_fix_unpack u_fxr (.word(wsr), .is_dbl(1'b0), .neg(nsr), .mag(msr));

  always_comb begin
    ctl_nxt = '{path: PATH_BAD, mix: 1'b0, right_valid: 1'b0, eob: in_end_of_block};
    il_nxt = '0;
    ir_nxt = '0;
    case (cfg_r.fmt)
      FMT_S16: begin
        ctl_nxt.path = PATH_PASS;
        il_nxt = 17'(signed'(in_chan0_word[15:0]));
      end
      FMT_U8P, FMT_U8: begin
        ctl_nxt.path = PATH_INT;
        ctl_nxt.right_valid = stereo && (cfg_r.fmt == FMT_U8P);
        il_nxt = {in_chan0_word[7:0], 8'd0} - 17'sd32768;
        ir_nxt = {in_chan1_word[7:0], 8'd0} - 17'sd32768;
      end
      FMT_S16P: begin
        ctl_nxt.path = PATH_INT;
        ctl_nxt.right_valid = stereo;
        il_nxt = 17'(signed'(in_chan0_word[15:0]));
        ir_nxt = 17'(signed'(in_chan1_word[15:0]));
      end
      FMT_S32P, FMT_S32: begin
        ctl_nxt.path = PATH_INT;
        ctl_nxt.right_valid = stereo && (cfg_r.fmt == FMT_S32P);
        il_nxt = 17'(signed'(in_chan0_word[31:16]));
        ir_nxt = 17'(signed'(in_chan1_word[31:16]));
      end
      FMT_FLTP: begin
        if (cfg_r.chans <= 4'd2) begin
          ctl_nxt.path = PATH_FIX;
          ctl_nxt.right_valid = stereo;
        end else if (cfg_r.chans == 4'd5 || cfg_r.chans == 4'd6) begin
          ctl_nxt.path = PATH_FIX;
          ctl_nxt.mix = 1'b1;
          ctl_nxt.right_valid = 1'b1;
        end
      end
      FMT_DBLP: begin
        ctl_nxt.path = PATH_FIX;
        ctl_nxt.right_valid = stereo;
      end
      FMT_FLT, FMT_DBL: ctl_nxt.path = PATH_FIX;
      default: ctl_nxt.path = PATH_BAD;
    endcase
  end

  // signed fixed values, 50 bits
  logic signed [49:0] f0_r, f1_r, f2_r, fsl_r, fsr_r;
  logic signed [16:0] il1_r, ir1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      ctl1_r <= ctl_nxt;
      il1_r  <= il_nxt;
      ir1_r  <= ir_nxt;
      f0_r   <= n0  ? -$signed({2'b0, m0})  : $signed({2'b0, m0});
      f1_r   <= n1  ? -$signed({2'b0, m1})  : $signed({2'b0, m1});
      f2_r   <= n2  ? -$signed({2'b0, m2})  : $signed({2'b0, m2});
      fsl_r  <= nsl ? -$signed({2'b0, msl}) : $signed({2'b0, msl});
      fsr_r  <= nsr ? -$signed({2'b0, msr}) : $signed({2'b0, msr});
    end
  end

  //---------------- stage 2: mix sum, upper third, int volume multiply ----------------
  logic signed [49:0] sl, sr;
  logic [49:0] al, ar;
  logic [23:0] hl_nxt, hr_nxt;
  logic [1:0]  reml_nxt, remr_nxt;
  logic signed [24:0] pl_nxt, pr_nxt;

  // floor(y/3) for y below 3*2^24: multiply by ceil(2^27/3)
  function automatic logic [23:0] div3_26(input logic [25:0] y);
    logic [51:0] q;
    q = y * 26'd44739243;
    return q[50:27];
  endfunction

  // mix magnitude split at bit 24: upper part divided here, remainder
  // carried down into the lower part next stage
  always_comb begin
    sl = f0_r + fsl_r + f2_r;
    sr = f1_r + fsr_r + f2_r;
    if (ctl1_r.mix) begin
      al = sl[49] ? 50'(-sl) : 50'(sl);
      ar = sr[49] ? 50'(-sr) : 50'(sr);
      hl_nxt = div3_26({1'b0, al[48:24]});
      hr_nxt = div3_26({1'b0, ar[48:24]});
      reml_nxt = 2'({1'b0, al[48:24]} - {2'b0, hl_nxt} * 26'd3);
      remr_nxt = 2'({1'b0, ar[48:24]} - {2'b0, hr_nxt} * 26'd3);
    end else begin
      al = f0_r[49] ? 50'(-f0_r) : 50'(f0_r);
      ar = f1_r[49] ? 50'(-f1_r) : 50'(f1_r);
      hl_nxt = al[47:24];
      hr_nxt = ar[47:24];
      reml_nxt = '0;
      remr_nxt = '0;
    end
    pl_nxt = il1_r * $signed({1'b0, ivol});
    pr_nxt = ir1_r * $signed({1'b0, ivol});
  end

  logic [23:0] hl2_r, hr2_r, lol2_r, lor2_r;
  logic [1:0]  reml2_r, remr2_r;
  logic        nl2_r, nr2_r;
  logic signed [24:0] pl2_r, pr2_r;
  logic signed [16:0] il2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      ctl2_r  <= ctl1_r;
      hl2_r   <= hl_nxt;
      hr2_r   <= hr_nxt;
      reml2_r <= reml_nxt;
      remr2_r <= remr_nxt;
      lol2_r  <= al[23:0];
      lor2_r  <= ar[23:0];
      nl2_r   <= ctl1_r.mix ? sl[49] : f0_r[49];
      nr2_r   <= ctl1_r.mix ? sr[49] : f1_r[49];
      pl2_r   <= pl_nxt;
      pr2_r   <= pr_nxt;
      il2_r   <= il1_r;
    end
  end

  //---------------- stage 3: lower third, cap ----------------
  logic [47:0] ml_nxt, mr_nxt;
  always_comb begin
    if (ctl2_r.mix) begin
      ml_nxt = {hl2_r, div3_26({reml2_r, lol2_r})};
      mr_nxt = {hr2_r, div3_26({remr2_r, lor2_r})};
    end else begin
      ml_nxt = {hl2_r, lol2_r};
      mr_nxt = {hr2_r, lor2_r};
    end
  end

  logic [47:0] ml3_r, mr3_r;
  logic        nl3_r, nr3_r;
  logic signed [24:0] pl3_r, pr3_r;
  logic signed [16:0] il3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      ctl3_r <= ctl2_r;
      ml3_r  <= (ml_nxt > FIX_CAP) ? FIX_CAP : ml_nxt;
      mr3_r  <= (mr_nxt > FIX_CAP) ? FIX_CAP : mr_nxt;
      nl3_r  <= nl2_r;
      nr3_r  <= nr2_r;
      pl3_r  <= pl2_r;
      pr3_r  <= pr2_r;
      il3_r  <= il2_r;
    end
  end

  //---------------- stage 4: scale multiply, int /100 ----------------
  logic [15:0] rl, rr;
  pcmfc_scale u_scl (.clk(clk), .en(adv), .mag(ml3_r), .scale(fscale), .res(rl));
  pcmfc_scale u_scr (.clk(clk), .en(adv), .mag(mr3_r), .scale(fscale), .res(rr));

  // signed /100 truncating toward zero, reciprocal plus correction
  function automatic logic signed [15:0] sdiv100(input logic signed [24:0] p);
    logic [23:0] a;
    logic [47:0] q;
    logic [23:0] d, r;
    a = p[24] ? 24'(-p) : 24'(p);
    q = a * 24'd167773;   // ceil-ish 2^24/100
    d = q[47:24];
    r = a - 24'(d * 24'd100);
    // estimate is never low, at most one high
    if (r[23]) d = d - 24'd1;
    else if (r >= 24'd100) d = d + 24'd1;
    return p[24] ? -$signed(d[15:0]) : $signed(d[15:0]);
  endfunction

  logic signed [15:0] idl4_r, idr4_r, pass4_r;
  logic nl4_r, nr4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
    if (adv) begin
      ctl4_r  <= ctl3_r;
      idl4_r  <= sdiv100(pl3_r);
      idr4_r  <= sdiv100(pr3_r);
      pass4_r <= il3_r[15:0];
      nl4_r   <= nl3_r;
      nr4_r   <= nr3_r;
    end
  end

  //---------------- stage 5: select output ----------------
  logic signed [15:0] lo_nxt, ro_nxt;
  always_comb begin
    lo_nxt = '0;
    ro_nxt = '0;
    case (ctl4_r.path)
      PATH_PASS: lo_nxt = pass4_r;
      PATH_INT: begin
        lo_nxt = idl4_r;
        ro_nxt = idr4_r;
      end
      PATH_FIX: begin
        lo_nxt = nl4_r ? -$signed(rl) : $signed(rl);
        ro_nxt = nr4_r ? -$signed(rr) : $signed(rr);
      end
      default: lo_nxt = '0;
    endcase
    if (!ctl4_r.right_valid) ro_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
    if (adv) begin
      ctl5_r           <= ctl4_r;
      out_left_sample  <= lo_nxt;
      out_right_sample <= ro_nxt;
    end
  end

  assign out_valid            = v5_r;
  assign out_right_valid      = ctl5_r.right_valid;
  assign out_unsupported      = (ctl5_r.path == PATH_BAD);
  assign out_end_of_block_out = ctl5_r.eob;
endmodule

@@ sv/pcmfc_checker.sv @@
//------------------------------------------------------------------------------
// pcmfc_checker
// Port-level checks on the core, attached by bind.
//------------------------------------------------------------------------------
module pcmfc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_left_sample,
  input logic signed [15:0] out_right_sample,
  input logic               out_right_valid,
  input logic               out_unsupported
);
  // stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_sample))
    else $error("output beat changed under stall");

  // input only blocked by a stalled output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // unsupported gives zero samples
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unsupported |-> out_left_sample == 16'sd0 && !out_right_valid)
    else $error("unsupported beat carries data");

  // no right sample without right_valid
  a_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_right_valid |-> out_right_sample == 16'sd0)
    else $error("right sample without right_valid");
endmodule

bind pcm_format_convert_downmix_core pcmfc_checker u_chk (.*);

@@ dv/pcm_format_convert_downmix_core_test.sv @@
//------------------------------------------------------------------------------
// pcm_format_convert_downmix_core_test
// Self-checking bench for the PCM format converter. A directed stimulus table
// is run first: format extremes, float specials, unsupported layouts and
// volume saturation. Random configuration phases with random frames follow.
// Every output beat is compared field by field with a table expectation or a local conversion model.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module pcm_format_convert_downmix_core_test;
  import pcmfc_pkg::*;

  localparam logic [63:0] CAP64 = 64'h0000_8000_0000_0000;
  localparam int          WDOG_LIMIT = 2000;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               rv;
    logic               bad;
    logic               eob;
  } pcm_out_t;

  typedef struct {
    logic [6:0]  fmt, ivol, fvol, chans;
    logic [63:0] w0, w1, w2, w3, w4, w5;
    logic        eob;
    logic        has_exp;
    pcm_out_t    exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [63:0] in_chan0_word = '0, in_chan1_word = '0, in_chan2_word = '0;
  logic [63:0] in_chan3_word = '0, in_chan4_word = '0, in_chan5_word = '0;
  logic in_end_of_block = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_left_sample, out_right_sample;
  logic out_right_valid, out_unsupported, out_end_of_block_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_FORMAT;
  logic [6:0] cfg_data = '0;

  pcm_format_convert_downmix_core dut (.*);

  // local copy of the register file
  logic [3:0] fmt_q = FMT_S16;
  logic [6:0] ivol_q = VOL_MAX;
  logic [6:0] fvol_q = VOL_MAX;
  logic [3:0] chans_q = 4'd2;

  pcm_out_t  pending_q[$];
  stim_row_t stim_tbl[$];
  int        err_cnt = 0;
  int        in_beats = 0;
  int        cfg_beats = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;
  logic      row_has_exp = 1'b0;
  pcm_out_t  row_exp;
  int        stall_left = 0;

  //--------------------------------------------------------------------------
  // Conversion model
  //--------------------------------------------------------------------------
  function automatic int vol_sat(logic [6:0] v);
    return (v > 7'd100) ? 100 : int'(v);
  endfunction

  function automatic int s16_val(logic [63:0] w);
    return int'($signed(w[15:0]));
  endfunction

  function automatic int int_scaled(int x);
    return x * vol_sat(ivol_q) / 100;
  endfunction

  function automatic int u8_scaled(logic [63:0] w);
    return int_scaled((int'(w[7:0]) - 128) * 256);
  endfunction

  // mantissa placed at 32 fraction bits, saturated at 2^47
  function automatic logic [63:0] fix_place(logic [63:0] mant, int s);
    logic [63:0] v;
    if (mant == 0) return '0;
    if (s >= 0) begin
      if (s > 47 || mant > (CAP64 >> s)) return CAP64;
      v = mant << s;
    end else begin
      if (-s >= 64) return '0;
      v = mant >> (-s);
    end
    return (v > CAP64) ? CAP64 : v;
  endfunction

  function automatic longint with_sign(logic neg, logic [63:0] m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fix_f32(logic [63:0] w);
    int          e;
    logic [63:0] f;
    e = int'(w[30:23]);
    f = {41'b0, w[22:0]};
    if (e == 255) return (f != 0) ? 64'sd0 : with_sign(w[31], CAP64);
    if (e == 0) return with_sign(w[31], fix_place(f, -117));
    return with_sign(w[31], fix_place(f | (64'd1 << 23), e - 118));
  endfunction

  function automatic longint fix_f64(logic [63:0] w);
    int          e;
    logic [63:0] f;
    e = int'(w[62:52]);
    f = {12'b0, w[51:0]};
    if (e == 2047) return (f != 0) ? 64'sd0 : with_sign(w[63], CAP64);
    if (e == 0) return with_sign(w[63], fix_place(f, -1042));
    return with_sign(w[63], fix_place(f | (64'd1 << 52), e - 1043));
  endfunction

  function automatic int fix_to_s16(longint v);
    logic        neg;
    logic [63:0] m, scale, r;
    neg = v < 0;
    m = neg ? 64'(-v) : 64'(v);
    scale = 64'(32767 * vol_sat(fvol_q) / 100);
    if (m > CAP64) m = CAP64;
    r = (m * scale) >> 32;
    if (r > 64'h7FFF) r = 64'h7FFF;
    return neg ? -int'(r) : int'(r);
  endfunction

  function automatic longint mix3_div(longint a, longint b, longint c);
    longint      s;
    logic [63:0] m;
    s = a + b + c;
    m = (s < 0) ? 64'(-s) : 64'(s);
    m = m / 3;
    return with_sign(s < 0, m);
  endfunction

  function automatic pcm_out_t convert_frame(logic [63:0] w0, w1, w2, w3, w4, w5,
                                             logic eob);
    pcm_out_t res;
    int       l, r;
    logic     stereo;
    longint   ctr;
    l = 0; r = 0;
    res.rv = 1'b0; res.bad = 1'b0; res.eob = eob;
    stereo = chans_q >= 4'd2;
    case (fmt_q)
      FMT_S16: l = s16_val(w0);
      FMT_U8P: begin
        l = u8_scaled(w0);
        if (stereo) begin r = u8_scaled(w1); res.rv = 1'b1; end
      end
      FMT_S16P: begin
        l = int_scaled(s16_val(w0));
        if (stereo) begin r = int_scaled(s16_val(w1)); res.rv = 1'b1; end
      end
      FMT_S32P: begin
        l = int_scaled(s16_val(w0 >> 16));
        if (stereo) begin r = int_scaled(s16_val(w1 >> 16)); res.rv = 1'b1; end
      end
      FMT_FLTP: begin
        if (chans_q <= 4'd2) begin
          l = fix_to_s16(fix_f32(w0));
          if (stereo) begin r = fix_to_s16(fix_f32(w1)); res.rv = 1'b1; end
        end else if (chans_q == 4'd5 || chans_q == 4'd6) begin
          // 3-way downmix: front + side + center
          ctr = fix_f32(w2);
          l = fix_to_s16(mix3_div(fix_f32(w0), fix_f32(chans_q == 4'd6 ? w4 : w3), ctr));
          r = fix_to_s16(mix3_div(fix_f32(w1), fix_f32(chans_q == 4'd6 ? w5 : w4), ctr));
          res.rv = 1'b1;
        end else begin
          res.bad = 1'b1;
        end
      end
      FMT_DBLP: begin
        l = fix_to_s16(fix_f64(w0));
        if (stereo) begin r = fix_to_s16(fix_f64(w1)); res.rv = 1'b1; end
      end
      FMT_U8:  l = u8_scaled(w0);
      FMT_S32: l = int_scaled(s16_val(w0 >> 16));
      FMT_FLT: l = fix_to_s16(fix_f32({32'b0, w0[31:0]}));
      FMT_DBL: l = fix_to_s16(fix_f64(w0));
      default: res.bad = 1'b1;
    endcase
    res.left = 16'(l);
    res.right = 16'(r);
    return res;
  endfunction

  //--------------------------------------------------------------------------
  // Clock, reset, output stalls
  //--------------------------------------------------------------------------
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // random stall bursts on the result side
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_ready <= rst_n;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(7) == 0) begin
      stall_left <= $urandom_range(14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  //--------------------------------------------------------------------------
  // Monitors and scoreboard
  //--------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    pcm_out_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FORMAT: fmt_q = cfg_data[3:0];
          REG_IVOL:   ivol_q = cfg_data;
          REG_FVOL:   fvol_q = cfg_data;
          REG_CHANS:  chans_q = cfg_data[3:0];
          default: ;
        endcase
        cfg_beats++;
      end
      if (in_valid && in_ready) begin
        want = row_has_exp ? row_exp
             : convert_frame(in_chan0_word, in_chan1_word, in_chan2_word,
                             in_chan3_word, in_chan4_word, in_chan5_word,
                             in_end_of_block);
        pending_q.push_back(want);
        in_beats++;
      end
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $display("ERROR %0t: output beat with nothing pending", $realtime);
          err_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (out_left_sample !== want.left)
            report_mismatch("left_sample", out_left_sample, want.left);
          if (out_right_sample !== want.right)
            report_mismatch("right_sample", out_right_sample, want.right);
          if (out_right_valid !== want.rv)
            report_mismatch("right_valid", out_right_valid, want.rv);
          if (out_unsupported !== want.bad)
            report_mismatch("unsupported", out_unsupported, want.bad);
          if (out_end_of_block_out !== want.eob)
            report_mismatch("end_of_block_out", out_end_of_block_out, want.eob);
        end
      end
      // watchdog: cycles with no beat on any channel
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("pcm_format_convert_downmix_core_test NOT OK");
        $finish;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus
  //--------------------------------------------------------------------------
  task automatic add_row(logic [6:0] fmt, ivol, fvol, chans, logic eob,
                         logic has_exp, int l, int r, logic rv, logic bad,
                         logic [63:0] w0, logic [63:0] w1 = 0, logic [63:0] w2 = 0,
                         logic [63:0] w3 = 0, logic [63:0] w4 = 0,
                         logic [63:0] w5 = 0);
    stim_row_t row;
    row.fmt = fmt; row.ivol = ivol; row.fvol = fvol; row.chans = chans;
    row.w0 = w0; row.w1 = w1; row.w2 = w2; row.w3 = w3; row.w4 = w4; row.w5 = w5;
    row.eob = eob;
    row.has_exp = has_exp;
    row.exp.left = 16'(l); row.exp.right = 16'(r);
    row.exp.rv = rv; row.exp.bad = bad; row.exp.eob = eob;
    stim_tbl.push_back(row);
  endtask

  // register writes happen only with the pipe drained
  task automatic write_regs(logic [6:0] fmt, ivol, fvol, chans);
    logic [6:0] vals[4];
    logic [1:0] idx[4];
    int         n0;
    vals = '{fmt, ivol, fvol, chans};
    idx = '{REG_FORMAT, REG_IVOL, REG_FVOL, REG_CHANS};
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    foreach (vals[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      n0 = cfg_beats;
      while (cfg_beats == n0) @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // one frame; called on a falling edge, returns on a falling edge
  task automatic send_frame(logic [63:0] w0, w1, w2, w3, w4, w5, logic eob);
    int n0;
    if (!calm && $urandom_range(5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_chan0_word <= w0; in_chan1_word <= w1; in_chan2_word <= w2;
    in_chan3_word <= w3; in_chan4_word <= w4; in_chan5_word <= w5;
    in_end_of_block <= eob;
    in_valid <= 1'b1;
    n0 = in_beats;
    while (in_beats == n0) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // raw word biased toward the interesting range of the current format
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    int          sel;
    w = rand64();
    sel = $urandom_range(7);
    if (sel < 2) return w;
    if (fmt_q == FMT_FLTP || fmt_q == FMT_FLT) begin
      if (sel == 2) w[30:23] = 8'd0;
      else if (sel == 3) w[30:23] = 8'd255;
      else w[30:23] = 8'($urandom_range(100, 135));
    end else if (fmt_q == FMT_DBLP || fmt_q == FMT_DBL) begin
      if (sel == 2) w[62:52] = 11'd0;
      else if (sel == 3) w[62:52] = 11'd2047;
      else w[62:52] = 11'($urandom_range(1005, 1035));
    end
    return w;
  endfunction

  function automatic logic [6:0] rand_vol();
    case ($urandom_range(4))
      0: return 7'd0;
      1: return VOL_MAX;
      2: return 7'($urandom_range(101, 127));
      default: return 7'($urandom_range(1, 99));
    endcase
  endfunction

  localparam logic [63:0] F_ONE = 64'h3F80_0000, F_MHALF = 64'hBF00_0000;
  localparam logic [63:0] F_QTR = 64'h3E80_0000, F_HALF = 64'h3F00_0000;
  localparam logic [63:0] F_MTWO = 64'hC000_0000, F_PINF = 64'h7F80_0000;
  localparam logic [63:0] F_NINF = 64'hFF80_0000, F_NAN = 64'h7FC0_0000;
  localparam logic [63:0] D_ONE = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] D_MONE = 64'hBFF0_0000_0000_0000;

  initial begin
    stim_row_t  row;
    logic [6:0] cur_fmt, cur_iv, cur_fv, cur_ch;
    logic [6:0] fmt_w, ch_w;
    int         n_items;

    // directed table: fmt, ivol, fvol, chans, eob, has_exp, left, right, rv, bad, words
    add_row(FMT_S16, 100, 100, 2, 0, 1, -32768, 0, 0, 0, 64'hFFFF_FFFF_FFFF_8000);
    add_row(FMT_S16, 100, 100, 2, 1, 1, 32767, 0, 0, 0, 64'h7FFF);
    add_row(FMT_U8P, 100, 100, 2, 0, 1, -32768, 32512, 1, 0, 64'h00, 64'hFF);
    add_row(FMT_S16P, 0, 100, 2, 1, 1, 0, 0, 1, 0, 64'h7FFF, 64'h8000);
    add_row(FMT_S16P, 127, 100, 2, 0, 0, 0, 0, 0, 0, 64'h8000, 64'h7FFF);
    add_row(FMT_S32P, 100, 100, 1, 0, 1, -32768, 0, 0, 0, 64'h8000_0000, 64'h7FFF_0000);
    add_row(FMT_S32P, 55, 100, 0, 0, 0, 0, 0, 0, 0, 64'h1234_5678, 64'h9ABC_DEF0);
    add_row(FMT_FLTP, 100, 100, 2, 0, 1, 32767, -32767, 1, 0, F_PINF, F_NINF);
    add_row(FMT_FLTP, 100, 100, 2, 1, 1, 0, 0, 1, 0, F_NAN, 64'h0000_0001);
    add_row(FMT_FLTP, 100, 100, 2, 0, 1, 32767, -16383, 1, 0, F_ONE, F_MHALF);
    add_row(FMT_FLTP, 100, 100, 3, 0, 1, 0, 0, 0, 1, F_ONE, F_ONE, F_ONE);
    add_row(FMT_FLTP, 100, 100, 4, 0, 1, 0, 0, 0, 1, F_ONE, F_ONE, F_ONE, F_ONE);
    add_row(FMT_FLTP, 100, 100, 7, 1, 1, 0, 0, 0, 1, F_ONE, F_ONE);
    add_row(FMT_FLTP, 100, 100, 6, 0, 0, 0, 0, 0, 0,
            F_ONE, F_MHALF, F_QTR, F_PINF, F_HALF, F_MTWO);
    add_row(FMT_FLTP, 60, 100, 5, 0, 0, 0, 0, 0, 0,
            F_MHALF, F_ONE, F_QTR, F_HALF, F_NINF, F_PINF);
    add_row(10, 100, 100, 2, 0, 1, 0, 0, 0, 1, 64'h1234);
    add_row(15, 100, 100, 2, 1, 1, 0, 0, 0, 1, 64'h1234);
    add_row(FMT_DBLP, 100, 100, 2, 0, 1, 32767, -32767, 1, 0, D_ONE, D_MONE);
    add_row(FMT_DBLP, 100, 100, 6, 0, 0, 0, 0, 0, 0, 64'h3FE0_0000_0000_0000, D_MONE);
    add_row(FMT_U8, 127, 100, 2, 1, 1, 0, 0, 0, 0, 64'h80);
    add_row(FMT_S32, 30, 100, 8, 0, 0, 0, 0, 0, 0, 64'hC000_0000);
    add_row(FMT_FLT, 100, 50, 2, 0, 1, 16383, 0, 0, 0, 64'hFFFF_FFFF_3F80_0000);
    add_row(FMT_DBL, 100, 0, 2, 0, 1, 0, 0, 0, 0, D_ONE);
    add_row(FMT_DBL, 100, 127, 15, 1, 0, 0, 0, 0, 0, 64'hC0E0_0000_0000_0000);

    cur_fmt = FMT_S16; cur_iv = VOL_MAX; cur_fv = VOL_MAX; cur_ch = 7'd2;
    @(posedge rst_n);
    @(negedge clk);

    foreach (stim_tbl[i]) begin
      row = stim_tbl[i];
      if ({row.fmt, row.ivol, row.fvol, row.chans} != {cur_fmt, cur_iv, cur_fv, cur_ch}) begin
        write_regs(row.fmt, row.ivol, row.fvol, row.chans);
        {cur_fmt, cur_iv, cur_fv, cur_ch} = {row.fmt, row.ivol, row.fvol, row.chans};
      end
      row_has_exp = row.has_exp;
      row_exp = row.exp;
      send_frame(row.w0, row.w1, row.w2, row.w3, row.w4, row.w5, row.eob);
    end
    row_has_exp = 1'b0;

    // random phases: new register setting each phase, last phases without idling
    for (int ph = 0; ph < 25; ph++) begin
      calm = (ph >= 22);
      fmt_w = {3'($urandom), 4'($urandom_range(0, 9))};
      if ($urandom_range(7) == 0) fmt_w[3:0] = 4'($urandom_range(10, 15));
      ch_w = {3'($urandom), 4'($urandom_range(0, 15))};
      if ($urandom_range(2) == 0) ch_w[3:0] = ($urandom_range(1) != 0) ? 4'd6 : 4'd5;
      write_regs(fmt_w, rand_vol(), rand_vol(), ch_w);
      n_items = $urandom_range(45, 75);
      for (int k = 0; k < n_items; k++)
        send_frame(rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), 1'($urandom));
    end
    in_valid <= 1'b0;

    // drain, then wait out anything stray
    while (pending_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0)
      $display("pcm_format_convert_downmix_core_test OK");
    else
      $display("pcm_format_convert_downmix_core_test NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pcmfc_pkg.sv
sv/pcmfc_fix_unpack.sv
sv/pcmfc_scale.sv
sv/pcm_format_convert_downmix_core.sv
sv/pcmfc_checker.sv
dv/pcm_format_convert_downmix_core_test.sv
